// File: rtl/luf_pkg.sv
// Package for the compact LU factorization block.
// Holds the fixed-point helpers and data types; no dependencies.
package luf_pkg;

    localparam int DW = 32;
    localparam int FB = 16;

    typedef logic signed [DW-1:0] word_t;

    function automatic word_t sat_word(input logic signed [2*DW:0] v);
        logic signed [2*DW:0] vmax;
        logic signed [2*DW:0] vmin;
        begin
            vmax = (2*DW+1)'((64'sd1 <<< (DW-1)) - 64'sd1);
            vmin = -vmax - (2*DW+1)'(1);
            if (v > vmax)
                sat_word = word_t'(vmax);
            else if (v < vmin)
                sat_word = word_t'(vmin);
            else
                sat_word = word_t'(v);
        end
    endfunction

endpackage

// File: rtl/luf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on luf_pkg.
module luf_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  luf_pkg::word_t   num,
    input  luf_pkg::word_t   den,
    output logic             done,
    output luf_pkg::word_t   quo
);
    import luf_pkg::*;

    localparam int QW = DW + FB;

    logic [QW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic signed [2*DW:0] sq;

    assign trial = {r_reg[DW-1:0], q_reg[QW-1]} - {1'b0, d_reg};
    assign sq = neg_reg ? -(2*DW+1)'({1'b0, q_reg}) : (2*DW+1)'({1'b0, q_reg});

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            q_next = {(num[DW-1] ? DW'(-num) : DW'(num)), FB'(0)};
            d_next = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next = num[DW-1] ^ den[DW-1];
            r_next = '0;
            cnt_next = 7'(QW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[DW])
            begin
                r_next = trial;
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[QW-1]};
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo = sat_word(sq);
endmodule

// File: rtl/luf_cell.sv
// One column cell: holds one row entry, forms entry minus l times pivot entry.
// Depends on luf_pkg.
module luf_cell
(
    input  logic           clk,
    input  logic           load,
    input  luf_pkg::word_t load_val,
    input  logic           upd,
    input  luf_pkg::word_t l_val,
    input  luf_pkg::word_t piv_val,
    input  logic           shift,
    input  luf_pkg::word_t shift_in,
    output luf_pkg::word_t val
);
    import luf_pkg::*;

    word_t val_reg, val_next;
    logic signed [2*DW-1:0] p;
    logic signed [2*DW:0] pr;
    logic signed [2*DW:0] diff;

    assign p = l_val * piv_val;
    assign pr = (2*DW+1)'(p >>> FB);
    assign diff = (2*DW+1)'(val_reg) - (2*DW+1)'(sat_word(pr));

    always_comb
    begin
        val_next = val_reg;
        if (load)
            val_next = load_val;
        else if (upd)
            val_next = sat_word(diff);
        else if (shift)
            val_next = shift_in;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
endmodule

// File: rtl/luf_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module luf_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/lu_factorization_compact.sv
// Top level of the compact LU factorization block.
// Depends on luf_pkg, luf_ram, luf_div and luf_cell.
//
// Usage:
//  - Write matrix_size with size_we/size_wdata while idle; a write drops any
//    partly loaded matrix. Sizes 0 and above 8 act as 1 and 8.
//  - Send n*n entries in row-major order: one transaction is taken at each
//    clock edge with start high and busy low.
//  - After the last entry busy rises. Each pivot step reads the pivot row into
//    a chain of 8 cells, then for each lower row reads it into the cells, runs
//    the divider for the multiplier, updates the columns right of the pivot
//    together, and writes the row back one word per cycle through the chain.
//  - Results then leave one per cycle with result_valid high, last_result on
//    the final one. A zero pivot gives one result: value 0, status 1.
//  - The receiver cannot stall; results are shown for one cycle each.
//  - Reset clears the control and sets matrix_size to 8; store content stays
//    undefined until loaded.
module lu_factorization_compact
#(
    parameter int MAX_N = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  luf_pkg::word_t entry_value,
    input  logic           size_we,
    input  logic [3:0]     size_wdata,
    output logic           result_valid,
    output luf_pkg::word_t result_value,
    output logic           status,
    output logic           last_result
);
    import luf_pkg::*;

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PREAD = 4'd1;
    localparam logic [3:0] S_PCAP  = 4'd2;
    localparam logic [3:0] S_RREAD = 4'd3;
    localparam logic [3:0] S_RCAP  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;

    logic [3:0]  st_reg, st_next;
    logic [3:0]  size_reg;
    logic [IW:0] n;
    logic [6:0]  ld_reg, ld_next;
    logic [6:0]  total;
    logic [IW:0] k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [6:0]  o_reg, o_next;
    word_t       piv_row [MAX_N];
    word_t       pivrow_reg [MAX_N];
    word_t       cell_val [MAX_N];
    word_t       l_reg;
    logic        ram_we;
    logic [AW-1:0] waddr, raddr;
    word_t       wdata, rdata;
    logic        div_go, div_done;
    word_t       div_q;
    logic        cell_load, cell_upd, cell_shift;
    logic        rv_reg;
    word_t       rval_reg;
    logic        rst_reg, rlast_reg;

    assign n = (size_reg == 4'd0) ? (IW+1)'(1) :
               (size_reg > 4'(MAX_N)) ? (IW+1)'(MAX_N) : (IW+1)'(size_reg);
    assign total = 7'(n) * 7'(n);

    luf_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram
    (
        .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    luf_div u_div
    (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(cell_val[k_reg[IW-1:0]]),
        .den(pivrow_reg[k_reg[IW-1:0]]), .done(div_done), .quo(div_q)
    );

    genvar g;
    generate
        for (g = 0; g < MAX_N; g++)
        begin : g_cell
            word_t sin;
            logic  upd_g;
            if (g == MAX_N - 1)
                assign sin = rdata;
            else
                assign sin = cell_val[g+1];
            assign upd_g = cell_upd && ((IW+1)'(g) > k_reg);
            luf_cell u_cell
            (
                .clk(clk), .load(cell_load && ((IW+1)'(g) == k_reg)),
                .load_val(div_q), .upd(upd_g), .l_val(l_reg),
                .piv_val(pivrow_reg[g]), .shift(cell_shift), .shift_in(sin),
                .val(cell_val[g])
            );
            assign piv_row[g] = cell_val[g];
        end
    endgenerate

    always_comb
    begin
        st_next = st_reg;
        ld_next = ld_reg;
        k_next = k_reg;
        i_next = i_reg;
        j_next = j_reg;
        o_next = o_reg;
        ram_we = 1'b0;
        waddr = AW'(ld_reg);
        wdata = entry_value;
        raddr = AW'(7'(i_reg) * 7'(n) + 7'(j_reg));
        div_go = 1'b0;
        cell_load = 1'b0;
        cell_upd = 1'b0;
        cell_shift = 1'b0;
        unique case (st_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    ram_we = 1'b1;
                    if (ld_reg + 7'd1 >= total)
                    begin
                        ld_next = '0;
                        k_next = '0;
                        i_next = '0;
                        j_next = '0;
                        st_next = (n == (IW+1)'(1)) ? S_OUT : S_PREAD;
                        o_next = '0;
                    end
                    else
                        ld_next = ld_reg + 7'd1;
                end
            end
            S_PREAD, S_RREAD:
            begin
                // stream row i through the chain: MAX_N reads, last word lands in capture
                cell_shift = (j_reg != '0);
                if (j_reg == (IW+1)'(MAX_N - 1))
                begin
                    st_next = (st_reg == S_PREAD) ? S_PCAP : S_RCAP;
                    j_next = '0;
                end
                else
                    j_next = j_reg + (IW+1)'(1);
                if (j_reg >= n)
                    raddr = '0;
            end
            S_PCAP:
            begin
                cell_shift = 1'b1;
                st_next = S_RREAD;
                i_next = k_reg + (IW+1)'(1);
            end
            S_RCAP:
            begin
                cell_shift = 1'b1;
                if (pivrow_reg[k_reg[IW-1:0]] == '0)
                    st_next = S_ERR;
                else
                    st_next = S_DIV;
            end
            S_DIV:
            begin
                div_go = (j_reg == '0);
                j_next = (IW+1)'(1);
                if (div_done)
                begin
                    cell_load = 1'b1;
                    st_next = S_UPD;
                    j_next = '0;
                end
            end
            S_UPD:
            begin
                cell_upd = 1'b1;
                st_next = S_WB;
            end
            S_WB:
            begin
                ram_we = (j_reg < n);
                waddr = AW'(7'(i_reg) * 7'(n) + 7'(j_reg));
                wdata = cell_val[0];
                cell_shift = 1'b1;
                if (j_reg == (IW+1)'(MAX_N - 1))
                begin
                    j_next = '0;
                    if (i_reg + (IW+1)'(1) < n)
                    begin
                        i_next = i_reg + (IW+1)'(1);
                        st_next = S_RREAD;
                    end
                    else if (k_reg + (IW+1)'(2) < n)
                    begin
                        k_next = k_reg + (IW+1)'(1);
                        i_next = k_reg + (IW+1)'(1);
                        st_next = S_PREAD;
                    end
                    else
                    begin
                        st_next = S_OUT;
                        o_next = '0;
                    end
                end
                else
                    j_next = j_reg + (IW+1)'(1);
            end
            S_OUT:
            begin
                raddr = AW'(o_reg);
                o_next = o_reg + 7'd1;
                if (o_reg == total)
                    st_next = S_LOAD;
            end
            S_ERR:
            begin
                st_next = S_LOAD;
            end
            default:
                st_next = S_LOAD;
        endcase
        if (size_we)
            ld_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD;
            size_reg <= 4'd8;
            ld_reg <= '0;
            k_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            o_reg <= '0;
            rv_reg <= 1'b0;
            rst_reg <= 1'b0;
            rlast_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ld_reg <= ld_next;
            k_reg <= k_next;
            i_reg <= i_next;
            j_reg <= j_next;
            o_reg <= o_next;
            if (size_we)
                size_reg <= size_wdata;
            rv_reg <= ((st_reg == S_OUT) && (o_reg != '0)) || (st_reg == S_ERR);
            rst_reg <= (st_reg == S_ERR);
            rlast_reg <= (st_reg == S_ERR) || ((st_reg == S_OUT) && (o_reg == total));
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_PCAP)
        begin
            for (int c = 0; c < MAX_N - 1; c++)
                pivrow_reg[c] <= piv_row[c+1];
            pivrow_reg[MAX_N-1] <= rdata;
        end
        if (st_reg == S_DIV && div_done)
            l_reg <= div_q;
        rval_reg <= (st_reg == S_ERR) ? '0 : rdata;
    end

    assign busy = (st_reg != S_LOAD);
    assign result_valid = rv_reg;
    assign result_value = rval_reg;
    assign status = rst_reg;
    assign last_result = rlast_reg;
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for lu_factorization_compact: loads matrices, predicts
// the compact LU result or zero-pivot error, and compares every result field.
// Depends on luf_pkg and the RTL top level.
module tb_top;

    localparam int MAXN = 8;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
        logic               last;
    } lu_word_t;

    typedef struct {
        logic [3:0]         mat_size;
        logic signed [31:0] value;
        logic               has_exp;
        lu_word_t           exp;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    luf_pkg::word_t entry_value;
    logic           size_we;
    logic [3:0]     size_wdata;
    logic           result_valid;
    luf_pkg::word_t result_value;
    logic           status;
    logic           last_result;

    lu_word_t       lu_expected[$];
    longint         mat[MAXN*MAXN];
    int             load_pos;
    int             size_reg;
    int             errors;
    int             idle_cycles;
    int             sender_idle_pct;
    stim_row_t      dir_rows[$];

    lu_factorization_compact dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .entry_value  (entry_value),
        .size_we      (size_we),
        .size_wdata   (size_wdata),
        .result_valid (result_valid),
        .result_value (result_value),
        .status       (status),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint p;
        longint r;
        p = a * b;
        if (p >= 0)
            r = p >>> 16;
        else
            r = -((-p + 65535) >>> 16);
        return clamp32(r);
    endfunction

    function automatic longint q_div(longint a, longint b);
        longint num;
        num = a * 65536;
        return clamp32(num / b);
    endfunction

    function automatic int active_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAXN)
            return MAXN;
        return size_reg;
    endfunction

    // accept one entry into the shadow matrix; factor when the matrix is full
    task automatic factor_entry(logic signed [31:0] v);
        int n;
        int total;
        longint piv;
        longint l;
        lu_word_t w;
        n = active_size();
        total = n * n;
        if (load_pos >= total)
            load_pos = 0;
        mat[load_pos] = v;
        load_pos++;
        if (load_pos < total)
            return;
        load_pos = 0;
        for (int k = 0; k + 1 < n; k++)
        begin
            piv = mat[k*n+k];
            if (piv == 0)
            begin
                w.value = '0;
                w.status = 1'b1;
                w.last = 1'b1;
                lu_expected.push_back(w);
                return;
            end
            for (int i = k + 1; i < n; i++)
            begin
                l = q_div(mat[i*n+k], piv);
                mat[i*n+k] = l;
                for (int j = k + 1; j < n; j++)
                    mat[i*n+j] = clamp32(mat[i*n+j] - q_mul(l, mat[k*n+j]));
            end
        end
        for (int i = 0; i < total; i++)
        begin
            w.value = mat[i][31:0];
            w.status = 1'b0;
            w.last = (i + 1 == total);
            lu_expected.push_back(w);
        end
    endtask

    always @(posedge clk)
    begin
        lu_word_t e;
        if (rst_n && result_valid)
        begin
            if (lu_expected.size() == 0)
            begin
                $error("unexpected result value=%0d status=%0b last=%0b",
                       result_value, status, last_result);
                errors++;
            end
            else
            begin
                e = lu_expected.pop_front();
                if (result_value !== e.value)
                begin
                    $error("result_value expected %0d actual %0d", e.value, result_value);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %0b actual %0b", e.status, status);
                    errors++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result expected %0b actual %0b", e.last, last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("lu_factorization_compact regression: fail");
            $finish;
        end
    end

    // send one entry, idling at random beforehand; hold start until accepted
    task automatic send_entry(logic signed [31:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        entry_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        factor_entry(v);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (lu_expected.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_size(logic [3:0] s);
        drain();
        size_we <= 1'b1;
        size_wdata <= s;
        @(posedge clk);
        size_we <= 1'b0;
        size_reg = s;
        load_pos = 0;
    endtask

    function automatic logic signed [31:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh0001_0000 * $signed($urandom_range(16) - 8);
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    task automatic add_row(logic [3:0] s, logic signed [31:0] v, logic chk, lu_word_t e);
        stim_row_t r;
        r.mat_size = s;
        r.value = v;
        r.has_exp = chk;
        r.exp = e;
        dir_rows.push_back(r);
    endtask

    initial
    begin
        int n;
        int pick;
        logic [3:0] cur_size;
        rst_n = 1'b0;
        start = 1'b0;
        entry_value = '0;
        size_we = 1'b0;
        size_wdata = 4'd8;
        errors = 0;
        idle_cycles = 0;
        load_pos = 0;
        size_reg = 8;
        cur_size = 4'd8;
        sender_idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 1x1 extremes, zero pivot error, 2x2 with last pivot zero, 2x2 extremes,
        // partial load dropped by a size write, oversized size on a full matrix
        add_row(4'd1, 32'sh7FFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 1'b1});
        add_row(4'd1, 32'sh8000_0000, 1'b1, '{32'sh8000_0000, 1'b0, 1'b1});
        add_row(4'd1, 32'sh0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 1'b1});
        add_row(4'd2, 32'sh0000_0000, 1'b0, '0);
        add_row(4'd2, 32'sh0001_0000, 1'b0, '0);
        add_row(4'd2, 32'sh0002_0000, 1'b0, '0);
        add_row(4'd2, 32'sh0003_0000, 1'b1, '{32'sh0000_0000, 1'b1, 1'b1});
        add_row(4'd2, 32'sh0001_0000, 1'b0, '0);
        add_row(4'd2, 32'sh0002_0000, 1'b0, '0);
        add_row(4'd2, 32'sh0000_8000, 1'b0, '0);
        add_row(4'd2, 32'sh0001_0000, 1'b0, '0);
        add_row(4'd2, 32'sh7FFF_FFFF, 1'b0, '0);
        add_row(4'd2, 32'sh8000_0000, 1'b0, '0);
        add_row(4'd2, 32'sh0000_0001, 1'b0, '0);
        add_row(4'd2, 32'sh8000_0000, 1'b0, '0);
        add_row(4'd3, 32'sh0001_0000, 1'b0, '0);
        add_row(4'd3, 32'sh0002_0000, 1'b0, '0);
        add_row(4'd0, 32'sh1234_5678, 1'b1, '{32'sh1234_5678, 1'b0, 1'b1});
        for (int i = 0; i < 64; i++)
            add_row(4'd15, (i % 9 == 0) ? 32'sh0004_0000 : rand_entry(), 1'b0, '0);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mat_size != cur_size)
            begin
                write_size(dir_rows[i].mat_size);
                cur_size = dir_rows[i].mat_size;
            end
            send_entry(dir_rows[i].value);
            if (dir_rows[i].has_exp && lu_expected.size() != 0 &&
                lu_expected[$] !== dir_rows[i].exp)
            begin
                $error("table row %0d disagrees with prediction", i);
                errors++;
            end
        end

        // random phases
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 17 : 0;
            pick = $urandom_range(15);
            if (pick > 4)
                pick = $urandom_range(2) + 1;
            write_size(pick[3:0]);
            n = active_size();
            for (int m = 0; m < (4 / (n * n)) + 1; m++)
                for (int i = 0; i < n * n; i++)
                    send_entry(((i / n == i % n) && $urandom_range(7) != 0)
                               ? $signed($urandom_range(32'h0010_0000) + 32'h0000_8000)
                               : rand_entry());
            drain();
        end
        drain();
        if (errors == 0)
            $display("lu_factorization_compact regression: pass");
        else
            $display("lu_factorization_compact regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/luf_pkg.sv
rtl/luf_div.sv
rtl/luf_cell.sv
rtl/luf_ram.sv
rtl/lu_factorization_compact.sv
tb/tb_top.sv
